// ----- src/camera_block_parser_pan_tilt_top_assert.svh -----
// Assertion macros for the camera block parser.
`ifndef CAMERA_BLOCK_PARSER_PAN_TILT_TOP_ASSERT_SVH
`define CAMERA_BLOCK_PARSER_PAN_TILT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CBPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CBPT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CBPT_ASSERT(label, prop, msg)
`define CBPT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- src/cbpt_pkg.sv -----
package cbpt_pkg;

    localparam int COORD_W = 16;
    localparam int DUTY_W  = 16;
    localparam int PHASE_W = 4;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MAG_W   = DIFF_W + 1;
    localparam int SUM_W   = DUTY_W + 3;
    localparam int ADDR_W  = 5;

    localparam logic [COORD_W-1:0] SYNC_WORD = 16'hAA55;

    localparam logic [PHASE_W-1:0] PH_WAIT_SYNC  = 4'd0;
    localparam logic [PHASE_W-1:0] PH_CHECK_SYNC = 4'd2;
    localparam logic [PHASE_W-1:0] PH_CAPTURE_X  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_CAPTURE_Y  = 4'd10;
    localparam logic [PHASE_W-1:0] PH_TRACK      = 4'd14;
    localparam logic [PHASE_W-1:0] PH_UNUSED     = 4'd15;

    localparam logic [2:0] REG_TARGET_X  = 3'd0;
    localparam logic [2:0] REG_TARGET_Y  = 3'd1;
    localparam logic [2:0] REG_DEAD_BAND = 3'd2;
    localparam logic [2:0] REG_DUTY_MIN  = 3'd3;
    localparam logic [2:0] REG_DUTY_MAX  = 3'd4;

    localparam logic [COORD_W-1:0] TARGET_X_RST  = 16'd157;
    localparam logic [COORD_W-1:0] TARGET_Y_RST  = 16'd103;
    localparam logic [COORD_W-1:0] DEAD_BAND_RST = 16'd10;
    localparam logic [DUTY_W-1:0]  DUTY_MIN_RST  = 16'd850;
    localparam logic [DUTY_W-1:0]  DUTY_MAX_RST  = 16'd4230;
    localparam logic [DUTY_W-1:0]  PAN_RST       = 16'd2240;
    localparam logic [DUTY_W-1:0]  TILT_RST      = 16'd3600;

    typedef struct packed {
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
        logic [COORD_W-1:0] dead_band;
        logic [DUTY_W-1:0]  duty_min;
        logic [DUTY_W-1:0]  duty_max;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] object_x;
        logic [COORD_W-1:0] object_y;
        logic [PHASE_W-1:0] phase;
    } track_req_t;

    function automatic logic [DUTY_W-1:0] clamp_duty(
        input logic signed [SUM_W-1:0] v,
        input logic [DUTY_W-1:0]       lo,
        input logic [DUTY_W-1:0]       hi
    );
        logic signed [SUM_W-1:0] r;
        logic signed [SUM_W-1:0] lo_s;
        logic signed [SUM_W-1:0] hi_s;
        begin
            lo_s = signed'({3'b000, lo});
            hi_s = signed'({3'b000, hi});
            r = v;
            if (r < lo_s)
            begin
                r = lo_s;
            end
            if (r > hi_s)
            begin
                r = hi_s;
            end
            return r[DUTY_W-1:0];
        end
    endfunction

endpackage

// ----- src/cbpt_cfg.sv -----
module cbpt_cfg
    import cbpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign index  = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_TARGET_X:  cfg_next.target_x  = pwdata[15:0];
                REG_TARGET_Y:  cfg_next.target_y  = pwdata[15:0];
                REG_DEAD_BAND: cfg_next.dead_band = pwdata[15:0];
                REG_DUTY_MIN:  cfg_next.duty_min  = pwdata[15:0];
                REG_DUTY_MAX:  cfg_next.duty_max  = pwdata[15:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_TARGET_X:  prdata = {16'h0000, cfg_reg.target_x};
            REG_TARGET_Y:  prdata = {16'h0000, cfg_reg.target_y};
            REG_DEAD_BAND: prdata = {16'h0000, cfg_reg.dead_band};
            REG_DUTY_MIN:  prdata = {16'h0000, cfg_reg.duty_min};
            REG_DUTY_MAX:  prdata = {16'h0000, cfg_reg.duty_max};
            default:       prdata = 32'h0000_0000;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_x  <= TARGET_X_RST;
            cfg_reg.target_y  <= TARGET_Y_RST;
            cfg_reg.dead_band <= DEAD_BAND_RST;
            cfg_reg.duty_min  <= DUTY_MIN_RST;
            cfg_reg.duty_max  <= DUTY_MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/cbpt_parser.sv -----
module cbpt_parser
    import cbpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [7:0] rx_byte,
    input  logic       req_taken,
    output track_req_t req
);

    logic [COORD_W-1:0] window_reg;
    logic [COORD_W-1:0] window_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [COORD_W-1:0] object_x_reg;
    logic [COORD_W-1:0] object_x_next;
    logic [COORD_W-1:0] object_y_reg;
    logic [COORD_W-1:0] object_y_next;
    logic               req_valid_reg;
    logic               req_valid_next;
    logic               track_hit;

    assign window_next = {rx_byte, window_reg[COORD_W-1:8]};

    always_comb
    begin
        phase_next    = phase_reg;
        object_x_next = object_x_reg;
        object_y_next = object_y_reg;
        track_hit     = 1'b0;
        if (in_fire)
        begin
            case (phase_reg)
                PH_WAIT_SYNC:
                begin
                    if (window_next == SYNC_WORD)
                    begin
                        phase_next = phase_reg + 4'd1;
                    end
                end
                PH_CHECK_SYNC:
                begin
                    phase_next = (window_next == SYNC_WORD) ? phase_reg + 4'd1 : PH_WAIT_SYNC;
                end
                PH_CAPTURE_X:
                begin
                    object_x_next = window_next;
                    phase_next    = phase_reg + 4'd1;
                end
                PH_CAPTURE_Y:
                begin
                    object_y_next = window_next;
                    phase_next    = phase_reg + 4'd1;
                end
                PH_TRACK:
                begin
                    track_hit  = 1'b1;
                    phase_next = PH_WAIT_SYNC;
                end
                default:
                begin
                    phase_next = phase_reg + 4'd1;
                end
            endcase
        end
    end

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (req_taken)
        begin
            req_valid_next = 1'b0;
        end
        if (track_hit)
        begin
            req_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            phase_reg     <= PH_WAIT_SYNC;
            object_x_reg  <= '0;
            object_y_reg  <= '0;
            req_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                window_reg <= window_next;
            end
            phase_reg     <= phase_next;
            object_x_reg  <= object_x_next;
            object_y_reg  <= object_y_next;
            req_valid_reg <= req_valid_next;
        end
    end

    assign req.valid    = req_valid_reg;
    assign req.object_x = object_x_reg;
    assign req.object_y = object_y_reg;
    assign req.phase    = phase_reg;

endmodule

// ----- src/cbpt_tracker.sv -----
module cbpt_tracker
    import cbpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  track_req_t        req,
    input  logic              out_stall,
    output logic              req_taken,
    output logic              out_valid,
    output logic [DUTY_W-1:0] pan_duty,
    output logic [DUTY_W-1:0] tilt_duty
);

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [DUTY_W-1:0]        pan_reg;
    logic [DUTY_W-1:0]        pan_next;
    logic [DUTY_W-1:0]        tilt_reg;
    logic [DUTY_W-1:0]        tilt_next;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [MAG_W-1:0]  dx_w;
    logic signed [MAG_W-1:0]  dy_w;
    logic signed [MAG_W-1:0]  db_w;
    logic                     outside;
    logic signed [SUM_W-1:0]  pan_sum;
    logic signed [SUM_W-1:0]  tilt_sum;

    assign req_taken = req.valid && (!out_valid_reg || !out_stall);

    assign dx   = signed'({1'b0, req.object_x}) - signed'({1'b0, cfg.target_x});
    assign dy   = signed'({1'b0, req.object_y}) - signed'({1'b0, cfg.target_y});
    assign dx_w = {dx[DIFF_W-1], dx};
    assign dy_w = {dy[DIFF_W-1], dy};
    assign db_w = signed'({2'b00, cfg.dead_band});

    assign outside = (dx_w > db_w) || (-dx_w > db_w) || (dy_w > db_w) || (-dy_w > db_w);

    assign pan_sum  = signed'({3'b000, pan_reg}) - {{(SUM_W-DIFF_W){dx[DIFF_W-1]}}, dx};
    assign tilt_sum = signed'({3'b000, tilt_reg}) + {{(SUM_W-DIFF_W){dy[DIFF_W-1]}}, dy};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pan_next       = pan_reg;
        tilt_next      = tilt_reg;
        if (req_taken)
        begin
            out_valid_next = outside;
            if (outside)
            begin
                pan_next  = clamp_duty(pan_sum, cfg.duty_min, cfg.duty_max);
                tilt_next = clamp_duty(tilt_sum, cfg.duty_min, cfg.duty_max);
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pan_reg       <= PAN_RST;
            tilt_reg      <= TILT_RST;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pan_reg       <= pan_next;
            tilt_reg      <= tilt_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pan_duty  = pan_reg;
    assign tilt_duty = tilt_reg;

endmodule

// ----- src/camera_block_parser_pan_tilt_top.sv -----
// Camera block parser with pan/tilt tracker. Takes one received byte per
// cycle while in_stall is low. A frame is the sync word 0xAA55 twice, four
// filler bytes, the x and y object coordinates and four filler bytes; on
// its last byte the tracker moves pan by -dx and tilt by +dy when either
// offset from the target exceeds the dead band, clamps both to the duty
// limits and presents them as one transfer. The parser registers a request
// on the last frame byte and the tracker registers its result from it; input
// is held off only while a result waits on a stalled output with a further
// frame already finished. Registers sit at byte addresses 0x00 (target_x),
// 0x04 (target_y), 0x08 (dead_band), 0x0C (duty_min) and 0x10 (duty_max).
`include "camera_block_parser_pan_tilt_top_assert.svh"

module camera_block_parser_pan_tilt_top
    import cbpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DUTY_W-1:0] pan_duty,
    output logic [DUTY_W-1:0] tilt_duty
);

    cfg_t       cfg;
    track_req_t req;
    logic       req_taken;
    logic       in_fire;

    assign in_stall = req.valid && !req_taken;
    assign in_fire  = in_valid && !in_stall;

    cbpt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cbpt_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .rx_byte   (rx_byte),
        .req_taken (req_taken),
        .req       (req)
    );

    cbpt_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .out_stall (out_stall),
        .req_taken (req_taken),
        .out_valid (out_valid),
        .pan_duty  (pan_duty),
        .tilt_duty (tilt_duty)
    );

    `CBPT_ASSERT(a_phase_in_range, req.phase != PH_UNUSED, "frame phase reached unused code")
    `CBPT_ASSERT(a_stall_needs_req, in_stall |-> (req.valid && out_valid && out_stall), "input held without pending result")
    `CBPT_ASSERT(a_result_from_req, $rose(out_valid) |-> $past(req_taken), "result without tracker request")
    `CBPT_ASSERT(a_req_from_track, $rose(req.valid) |-> $past(req.phase == PH_TRACK), "request outside last frame byte")

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import cbpt_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 16;

    localparam logic [7:0] SYNC_LO = SYNC_WORD[7:0];
    localparam logic [7:0] SYNC_HI = SYNC_WORD[15:8];

    localparam logic [2:0] REG_SPARE = 3'd5;

    typedef struct {
        logic [DUTY_W-1:0] pan;
        logic [DUTY_W-1:0] tilt;
    } servo_cmd_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [7:0]        rx_byte = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DUTY_W-1:0] pan_duty;
    logic [DUTY_W-1:0] tilt_duty;

    camera_block_parser_pan_tilt_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pan_duty  (pan_duty),
        .tilt_duty (tilt_duty)
    );

    always #4 clk = ~clk;

    cfg_t cfg_model = '{TARGET_X_RST, TARGET_Y_RST, DEAD_BAND_RST, DUTY_MIN_RST, DUTY_MAX_RST};

    logic [COORD_W-1:0] win_model = '0;
    logic [PHASE_W-1:0] phase_model = PH_WAIT_SYNC;
    logic [COORD_W-1:0] obj_x_model = '0;
    logic [COORD_W-1:0] obj_y_model = '0;
    logic [DUTY_W-1:0]  pan_model = PAN_RST;
    logic [DUTY_W-1:0]  tilt_model = TILT_RST;

    logic [7:0] rx_pending[$];
    servo_cmd_t servo_q[$];

    int  errors = 0;
    int  bytes_accepted = 0;
    int  updates_checked = 0;
    int  cfg_sets = 0;
    int  drain_count = 0;
    int  cycle_count = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  drain_hold = 1'b0;

    task automatic flag_error(input string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DUTY_W-1:0] clamp_servo(input int v);
        if (v < int'(cfg_model.duty_min))
            v = int'(cfg_model.duty_min);
        if (v > int'(cfg_model.duty_max))
            v = int'(cfg_model.duty_max);
        return v[DUTY_W-1:0];
    endfunction

    // Returns 1 when the byte completes a frame that moves the servos.
    function automatic bit parse_byte(input logic [7:0] b);
        int dx;
        int dy;
        int db;
        servo_cmd_t cmd;
        bit moved;
        moved = 1'b0;
        win_model = {b, win_model[15:8]};
        case (phase_model)
            PH_WAIT_SYNC:
            begin
                if (win_model == SYNC_WORD)
                    phase_model = PH_WAIT_SYNC + 1'b1;
            end
            PH_CHECK_SYNC:
            begin
                phase_model = (win_model == SYNC_WORD) ? PH_CHECK_SYNC + 1'b1 : PH_WAIT_SYNC;
            end
            PH_CAPTURE_X:
            begin
                obj_x_model = win_model;
                phase_model = PH_CAPTURE_X + 1'b1;
            end
            PH_CAPTURE_Y:
            begin
                obj_y_model = win_model;
                phase_model = PH_CAPTURE_Y + 1'b1;
            end
            PH_TRACK:
            begin
                dx = int'(obj_x_model) - int'(cfg_model.target_x);
                dy = int'(obj_y_model) - int'(cfg_model.target_y);
                db = int'(cfg_model.dead_band);
                if (dx > db || -dx > db || dy > db || -dy > db)
                begin
                    pan_model = clamp_servo(int'(pan_model) - dx);
                    tilt_model = clamp_servo(int'(tilt_model) + dy);
                    cmd.pan = pan_model;
                    cmd.tilt = tilt_model;
                    servo_q.push_back(cmd);
                    moved = 1'b1;
                end
                phase_model = PH_WAIT_SYNC;
            end
            default:
            begin
                phase_model = phase_model + 1'b1;
            end
        endcase
        return moved;
    endfunction

    // Input driver: advance through pending bytes with random gaps and drain pauses, hold while stalled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (parse_byte(rx_byte) && (drain_count == 0 || $urandom_range(0, 4) == 0))
                begin
                    drain_hold = 1'b1;
                    drain_count++;
                end
                bytes_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (drain_hold && servo_q.size() != 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (gap_left > 0)
                begin
                    drain_hold = 1'b0;
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (rx_pending.size() != 0)
                begin
                    drain_hold = 1'b0;
                    rx_byte <= rx_pending.pop_front();
                    in_valid <= 1'b1;
                    gap_left = pick_gap((bytes_accepted % 160) < 40);
                end
                else
                begin
                    drain_hold = 1'b0;
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: check each transfer, stall at random.
    always @(posedge clk)
    begin
        servo_cmd_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (servo_q.size() == 0)
                begin
                    flag_error($sformatf("unexpected servo update pan=%0d tilt=%0d",
                                         pan_duty, tilt_duty));
                end
                else
                begin
                    want = servo_q.pop_front();
                    if (pan_duty !== want.pan)
                        flag_error($sformatf("pan_duty expected %0d got %0d", want.pan, pan_duty));
                    if (tilt_duty !== want.tilt)
                        flag_error($sformatf("tilt_duty expected %0d got %0d",
                                             want.tilt, tilt_duty));
                    updates_checked++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap((cycle_count % 1000) < 250);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("camera_block_parser_pan_tilt_top verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TARGET_X:  cfg_model.target_x = value;
            REG_TARGET_Y:  cfg_model.target_y = value;
            REG_DEAD_BAND: cfg_model.dead_band = value;
            REG_DUTY_MIN:  cfg_model.duty_min = value;
            REG_DUTY_MAX:  cfg_model.duty_max = value;
            default:       ;
        endcase
    endtask

    task automatic program_cfg(input logic [15:0] tx, input logic [15:0] ty,
                               input logic [15:0] db, input logic [15:0] lo,
                               input logic [15:0] hi);
        write_reg(REG_TARGET_X, tx);
        write_reg(REG_TARGET_Y, ty);
        write_reg(REG_DEAD_BAND, db);
        write_reg(REG_DUTY_MIN, lo);
        write_reg(REG_DUTY_MAX, hi);
        write_reg(REG_SPARE, 16'($urandom));
        cfg_sets++;
    endtask

    function automatic logic [15:0] pick_coord(input logic [15:0] tgt, input logic [15:0] db);
        int sel;
        int off;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3:
            begin
                off = $urandom_range(0, 2 * int'(db)) - int'(db);
                return 16'(int'(tgt) + off);
            end
            4: return ($urandom_range(0, 1) != 0) ? 16'(int'(tgt) + int'(db) + 1)
                                                   : 16'(int'(tgt) - int'(db) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_frame(input logic [15:0] x, input logic [15:0] y);
        rx_pending.push_back(SYNC_LO);
        rx_pending.push_back(SYNC_HI);
        rx_pending.push_back(SYNC_LO);
        rx_pending.push_back(SYNC_HI);
        repeat (4) rx_pending.push_back(8'($urandom));
        rx_pending.push_back(x[7:0]);
        rx_pending.push_back(x[15:8]);
        rx_pending.push_back(y[7:0]);
        rx_pending.push_back(y[15:8]);
        repeat (4) rx_pending.push_back(8'($urandom));
    endtask

    task automatic queue_traffic(input int n);
        int made;
        int sel;
        int cnt;
        logic [7:0] b;
        made = 0;
        while (made < n)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 75)
            begin
                queue_frame(pick_coord(cfg_model.target_x, cfg_model.dead_band),
                            pick_coord(cfg_model.target_y, cfg_model.dead_band));
                made += 16;
            end
            else if (sel < 85)
            begin
                cnt = $urandom_range(1, 6);
                repeat (cnt) rx_pending.push_back(8'($urandom));
                made += cnt;
            end
            else if (sel < 93)
            begin
                b = 8'($urandom);
                if (b == SYNC_HI)
                    b = ~b;
                rx_pending.push_back(SYNC_LO);
                rx_pending.push_back(SYNC_HI);
                rx_pending.push_back(SYNC_LO);
                rx_pending.push_back(b);
                made += 4;
            end
            else
            begin
                cnt = $urandom_range(1, 10);
                rx_pending.push_back(SYNC_LO);
                rx_pending.push_back(SYNC_HI);
                rx_pending.push_back(SYNC_LO);
                rx_pending.push_back(SYNC_HI);
                repeat (cnt) rx_pending.push_back(8'($urandom));
                made += 4 + cnt;
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (rx_pending.size() != 0 || in_valid || servo_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [15:0] lim;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        queue_frame(16'hFFFF, 16'h0000);
        rx_pending.push_back(SYNC_LO);
        rx_pending.push_back(SYNC_HI);
        rx_pending.push_back(SYNC_LO);
        rx_pending.push_back(8'h00);
        queue_traffic(80);
        wait_idle();

        program_cfg(16'h0000, 16'hFFFF, 16'h0000, 16'd0, 16'd40000);
        queue_traffic(90);
        wait_idle();

        program_cfg(16'hFFFF, 16'h0000, 16'hFFFF, 16'd40000, 16'd40000);
        queue_traffic(40);
        wait_idle();

        program_cfg(16'($urandom), 16'($urandom), 16'($urandom_range(0, 200)),
                    16'($urandom_range(20000, 40000)), 16'($urandom_range(0, 19999)));
        queue_traffic(90);
        wait_idle();

        program_cfg(16'($urandom), 16'($urandom), 16'($urandom_range(0, 50)),
                    16'($urandom_range(0, 2000)), 16'($urandom_range(2000, 40000)));
        queue_traffic(110);
        wait_idle();

        lim = 16'($urandom_range(0, 40000));
        program_cfg(16'($urandom), 16'($urandom), 16'($urandom_range(0, 300)), lim, lim);
        queue_traffic(90);
        wait_idle();

        if (servo_q.size() != 0)
            flag_error($sformatf("%0d servo updates never arrived", servo_q.size()));

        $display("summary: %0d bytes accepted, %0d servo updates checked, %0d register settings",
                 bytes_accepted, updates_checked, cfg_sets);
        $display("summary: frames, broken syncs and noise with random gaps and stalls, %0d drains",
                 drain_count);
        if (errors == 0)
            $display("camera_block_parser_pan_tilt_top verification clean");
        else
            $display("camera_block_parser_pan_tilt_top verification failed");
        $finish;
    end

endmodule
